// ----- rtl/core/waypoint_linear_interpolator_macros.svh -----
// Assertion macros for the waypoint interpolator
`ifndef WAYPOINT_LINEAR_INTERPOLATOR_MACROS_SVH
`define WAYPOINT_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define WLI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define WLI_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define WLI_ASSERT(label, clk, rst_n, prop)
`define WLI_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/wli_pkg.sv -----
// ----------------------------------------------------------------------------
// wli_pkg
// Types and constants shared by the waypoint interpolator modules.
// ----------------------------------------------------------------------------
package wli_pkg;
	localparam int MaxSubdivDefault = 63;
	localparam logic [5:0] SubdivReset = 6'd8;
	localparam int PtW = 32;
	localparam int AngW = 24;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [23:0] pa;
		logic signed [31:0] ps;
		logic signed [31:0] pscore;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [23:0] ca;
		logic signed [31:0] cs;
		logic signed [31:0] cscore;
		logic               interp;
		logic               fin;
		logic [5:0]         n;
	} job_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [23:0] a;
		logic signed [31:0] s;
		logic signed [31:0] score;
		logic               last;
	} point_t;
endpackage

// ----- rtl/core/wli_front.sv -----
// ----------------------------------------------------------------------------
// wli_front
// Accepts waypoints, holds the segment start and issues jobs to the queue.
// ----------------------------------------------------------------------------
module wli_front #(
	parameter int MAX_SUBDIVISIONS = wli_pkg::MaxSubdivDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [5:0]         subdiv,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [23:0] angle,
	input  logic signed [31:0] scale,
	input  logic signed [31:0] score_in,
	input  logic               final_point,
	output logic               job_valid,
	input  logic               job_ready,
	output wli_pkg::job_t      job
);
	localparam logic [5:0] MaxN = 6'(MAX_SUBDIVISIONS);
	logic have_q;
	logic signed [31:0] px_q, py_q, ps_q, pscore_q;
	logic signed [23:0] pa_q;
	logic [5:0] n;

	always_comb begin
		n = subdiv;
		if (n == 6'd0) n = 6'd1;
		if (n > MaxN) n = MaxN;
	end

	assign in_ready = job_ready;
	assign job_valid = in_valid && (have_q || final_point);
	assign job = '{px: px_q, py: py_q, pa: pa_q, ps: ps_q, pscore: pscore_q,
		cx: pos_x, cy: pos_y, ca: angle, cs: scale, cscore: score_in,
		interp: have_q, fin: final_point, n: n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			have_q <= !final_point;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pa_q <= angle;
			ps_q <= scale;
			pscore_q <= score_in;
		end
	end
endmodule

// ----- rtl/core/wli_queue.sv -----
// ----------------------------------------------------------------------------
// wli_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`include "waypoint_linear_interpolator_macros.svh"
module wli_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  wli_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output wli_pkg::job_t rd_job
);
	wli_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	`WLI_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3)
	`WLI_ASSERT(a_ptr_match, clk, arst_n, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
	`WLI_ASSERT(a_full_hold, clk, arst_n, (cnt_q == 2'd2 && !rd) |=> cnt_q == 2'd2)
endmodule

// ----- rtl/core/wli_back.sv -----
// ----------------------------------------------------------------------------
// wli_back
// Steps k through a segment and emits interpolated points, and emits a final waypoint
// as it is. Per point: multiply delta by k, then divide by N by restoring division.
// ----------------------------------------------------------------------------
`include "waypoint_linear_interpolator_macros.svh"
module wli_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  wli_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output wli_pkg::point_t pt
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StFin  = 2'd2;

	logic [1:0] st_q;
	logic [5:0] k_q;
	logic [5:0] cyc_q;
	logic [6:0] col_q;
	logic signed [33:0] d_q [4];
	logic signed [40:0] prod_q;
	logic [40:0] mag_q, rem_q, quo_q;
	logic neg_q;
	logic signed [31:0] res_q [4];
	logic out_v_q;
	wli_pkg::point_t pt_q;
	logic signed [33:0] dsel;
	logic [40:0] rem_nxt;
	logic signed [31:0] base;
	logic signed [40:0] qs;
	logic launch, emit;

	assign launch = !out_v_q || out_ready;
	assign emit = launch && ((st_q == StRun && col_q == 7'd4) || st_q == StFin);
	assign job_ready = emit && (st_q == StFin || (k_q == job.n - 6'd1 && !job.fin));
	assign out_valid = out_v_q;
	assign pt = pt_q;

	// restoring division of |delta*k| by N, one bit per cycle, lane by lane
	always_comb begin
		dsel = d_q[col_q[1:0]];
		rem_nxt = {rem_q[39:0], mag_q[40]};
		case (col_q[1:0])
			2'd0: base = job.px;
			2'd1: base = job.py;
			2'd2: base = 32'(job.pa);
			default: base = job.ps;
		endcase
		qs = neg_q ? -$signed(quo_q) : $signed(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			out_v_q <= 1'b0;
			k_q <= '0;
			cyc_q <= '0;
			col_q <= '0;
		end else begin
			if (emit) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			case (st_q)
				StIdle: begin
					if (job_valid) begin
						k_q <= '0;
						col_q <= '0;
						cyc_q <= '0;
						st_q <= job.interp ? StRun : StFin;
					end
				end
				StRun: begin
					if (col_q == 7'd4) begin
						if (launch) begin
							col_q <= '0;
							cyc_q <= '0;
							if (k_q == job.n - 6'd1) begin
								k_q <= '0;
								st_q <= job.fin ? StFin : StIdle;
							end else begin
								k_q <= k_q + 6'd1;
							end
						end
					end else if (cyc_q == 6'd0) begin
						cyc_q <= 6'd1;
					end else if (cyc_q <= 6'd42) begin
						cyc_q <= cyc_q + 6'd1;
					end else begin
						col_q <= col_q + 7'd1;
						cyc_q <= '0;
					end
				end
				StFin: begin
					if (launch) begin
						st_q <= StIdle;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		d_q[0] <= 34'(job.cx) - 34'(job.px);
		d_q[1] <= 34'(job.cy) - 34'(job.py);
		d_q[2] <= 34'(job.ca) - 34'(job.pa);
		d_q[3] <= 34'(job.cs) - 34'(job.ps);
		if (st_q == StRun && col_q < 7'd4) begin
			if (cyc_q == 6'd0) begin
				prod_q <= 41'(dsel) * $signed({1'b0, k_q});
			end else if (cyc_q == 6'd1) begin
				neg_q <= prod_q[40];
				mag_q <= prod_q[40] ? 41'(-prod_q) : 41'(prod_q);
				rem_q <= '0;
				quo_q <= '0;
			end else if (cyc_q <= 6'd42) begin
				if (rem_nxt >= 41'(job.n)) begin
					rem_q <= rem_nxt - 41'(job.n);
					quo_q <= {quo_q[39:0], 1'b1};
				end else begin
					rem_q <= rem_nxt;
					quo_q <= {quo_q[39:0], 1'b0};
				end
				mag_q <= {mag_q[39:0], 1'b0};
			end else begin
				res_q[col_q[1:0]] <= 32'(base + 32'(qs));
			end
		end
		if (st_q == StRun && col_q == 7'd4 && launch) begin
			pt_q <= '{x: res_q[0], y: res_q[1], a: res_q[2][23:0], s: res_q[3],
				score: job.pscore, last: !job.fin && (k_q == job.n - 6'd1)};
		end
		if (st_q == StFin && launch) begin
			pt_q <= '{x: job.cx, y: job.cy, a: job.ca, s: job.cs,
				score: job.cscore, last: 1'b1};
		end
	end

	`WLI_ASSERT_NEVER(a_st_valid, clk, arst_n, st_q != StIdle && st_q != StRun && st_q != StFin)
	`WLI_ASSERT(a_k_range, clk, arst_n, (st_q == StRun) |-> k_q < job.n)
	`WLI_ASSERT(a_emit_hold, clk, arst_n, (out_v_q && !out_ready) |=> $stable(pt_q))
endmodule

// ----- rtl/core/waypoint_linear_interpolator.sv -----
// Each point passes its four coordinates in turn through the shared multiply and
// bit-serial divide unit and is then emitted. The two-entry queue lets new
// waypoints be accepted while a segment is still being interpolated.
// Reset: asynchronous, clears the stored waypoint, the queue and N to 8.
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator
// Linear interpolation upsampler of waypoint streams.
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator #(
	parameter int MAX_SUBDIVISIONS = wli_pkg::MaxSubdivDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [23:0] angle,
	input  logic signed [31:0] scale,
	input  logic signed [31:0] score_in,
	input  logic               final_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [23:0] out_angle,
	output logic signed [31:0] out_scale,
	output logic signed [31:0] out_score,
	output logic               last_of_run
);
	logic [5:0] subdiv_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	wli_pkg::job_t fj, bj;
	wli_pkg::point_t pt;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {26'd0, subdiv_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= wli_pkg::SubdivReset;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			subdiv_q <= pwdata[5:0];
		end
	end

	wli_front #(.MAX_SUBDIVISIONS(MAX_SUBDIVISIONS)) u_front (
		.clk, .arst_n, .subdiv(subdiv_q), .in_valid, .in_ready,
		.pos_x, .pos_y, .angle, .scale, .score_in, .final_point,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	wli_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
	);

	wli_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid, .out_ready, .pt
	);

	assign out_x = pt.x;
	assign out_y = pt.y;
	assign out_angle = pt.a;
	assign out_scale = pt.s;
	assign out_score = pt.score;
	assign last_of_run = pt.last;
endmodule
